### rtl/fsbg_pkg.sv
package fsbg_pkg;

  localparam int HIST_DEPTH = 2048;               // power of two
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SIZE_W     = 24;
  localparam int FKIND_W    = 2;
  localparam int ENT_W      = SIZE_W + FKIND_W;
  localparam int HQ_W       = 10;
  localparam int PROD_W     = SIZE_W + HQ_W;
  localparam int DCNT_W     = $clog2(PROD_W + 1);

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [11:0] RST_WIDTH  = 12'd640;
  localparam logic [11:0] RST_HEIGHT = 12'd480;

  typedef enum logic [1:0] {
    OP_FRAME,
    OP_PIXEL,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                hit;     // pixel inside picture, window and enabled
    logic [10:0]         col;
    logic [11:0]         rows_up; // rows from bottom
    logic [HQ_W-1:0]     hq;      // height / 4
    logic [SIZE_W-1:0]   size;
    logic [FKIND_W-1:0]  fkind;
    logic [7:0]          luma;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAX,
    S_PX_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PX_OUT
  } state_t;

  function automatic logic [CNT_W-1:0] win_width(input logic [11:0] pw);
    if (int'(pw) > HIST_DEPTH) return CNT_W'(HIST_DEPTH);
    else return CNT_W'(pw);
  endfunction

  function automatic logic [7:0] type_luma(input logic [FKIND_W-1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = 8'd255;
      2'd1:    v = 8'd210;
      2'd2:    v = 8'd170;
      default: v = 8'd130;
    endcase
    return v;
  endfunction

endpackage

### rtl/frame_size_bar_graph_overlay_top.sv
// Frame-size bar graph overlay.
// Input channel (in_valid / in_stall) carries one item per transfer: a frame
// record (size, type), a pixel (column, row, luma) or a history clear.
// Output channel (out_valid / out_stall) carries one luma per pixel transfer,
// in input order. Frame and clear transfers produce nothing.
// Config port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 enable, 1 picture width, 2 picture height. Write only when idle.
// A two-entry command queue sits between the classifier and the engine, so
// input transfers keep landing while a result waits on out_stall.
// Steps through the engine:
//   pixel drawn: queue entry, history read, multiply, then the 34-step
//     serial divider, then the output register
//   pixel passed through: queue entry, then the output register
//   frame: history write, then min(width, stored entries) reads, one a cycle
//   clear: fill count and maximum reset while idle
// The history is a circular RAM with a fill count, so reset and clear take
// effect at once with no sweep. Reset restores enable=1, width 640,
// height 480 and an empty history. A stalled result holds and the engine
// waits on it; the queue fills and then in_stall rises.
module frame_size_bar_graph_overlay_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic [fsbg_pkg::SIZE_W-1:0]  in_frame_size,
  input  logic [fsbg_pkg::FKIND_W-1:0] in_frame_kind,
  input  logic [10:0]                  in_column,
  input  logic [11:0]                  in_row,
  input  logic [7:0]                   in_luma_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_luma_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [11:0]                  cfg_data
);

  logic           enable_r;
  logic [11:0]    width_r, height_r;
  logic           cmd_valid, cmd_pop;
  fsbg_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      width_r  <= fsbg_pkg::RST_WIDTH;
      height_r <= fsbg_pkg::RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fsbg_pkg::REG_ENABLE: enable_r <= cfg_data[0];
        fsbg_pkg::REG_WIDTH:  width_r  <= cfg_data;
        fsbg_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  fsbg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_frame_size  (in_frame_size),
    .in_frame_kind  (in_frame_kind),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_luma_in     (in_luma_in),
    .overlay_enable (enable_r),
    .picture_width  (width_r),
    .picture_height (height_r),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  fsbg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .picture_width (width_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_luma_out  (out_luma_out)
  );

endmodule

### rtl/fsbg_ram.sv
module fsbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/fsbg_div.sv
module fsbg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fsbg_pkg::PROD_W-1:0] dividend,
  input  logic [fsbg_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [fsbg_pkg::PROD_W-1:0] quotient
);

  logic [fsbg_pkg::PROD_W-1:0] quo_r, quo_nxt;
  logic [fsbg_pkg::SIZE_W:0]   rem_r, rem_nxt;
  logic [fsbg_pkg::SIZE_W-1:0] div_r, div_nxt;
  logic [fsbg_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [fsbg_pkg::SIZE_W:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[fsbg_pkg::SIZE_W-1:0], quo_r[fsbg_pkg::PROD_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
        quo_nxt = {quo_r[fsbg_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[fsbg_pkg::PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == fsbg_pkg::DCNT_W'(fsbg_pkg::PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/fsbg_front.sv
module fsbg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic [fsbg_pkg::SIZE_W-1:0]  in_frame_size,
  input  logic [fsbg_pkg::FKIND_W-1:0] in_frame_kind,
  input  logic [10:0]                  in_column,
  input  logic [11:0]                  in_row,
  input  logic [7:0]                   in_luma_in,
  input  logic                         overlay_enable,
  input  logic [11:0]                  picture_width,
  input  logic [11:0]                  picture_height,
  output logic                         cmd_valid,
  output fsbg_pkg::cmd_t               cmd,
  input  logic                         cmd_pop
);

  fsbg_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  fsbg_pkg::cmd_t dec;
  logic           push, keep;
  logic [fsbg_pkg::CNT_W-1:0] w;

  // classify: kind 3 and frames while disabled are dropped here
  always_comb begin
    w           = fsbg_pkg::win_width(picture_width);
    dec         = '0;
    keep        = 1'b0;
    dec.size    = in_frame_size;
    dec.fkind   = in_frame_kind;
    dec.col     = in_column;
    dec.luma    = in_luma_in;
    dec.hq      = picture_height[11:2];
    dec.rows_up = picture_height - 12'd1 - in_row;
    // top row is never covered: pixels in row 0 never hit
    dec.hit     = overlay_enable && (picture_height != 12'd0) && (in_row != 12'd0) &&
                  (32'(in_column) < 32'(w)) && (in_row < picture_height);
    dec.op      = fsbg_pkg::OP_PIXEL;
    unique case (in_kind)
      fsbg_pkg::KIND_FRAME: begin
        dec.op = fsbg_pkg::OP_FRAME;
        keep   = overlay_enable;
      end
      fsbg_pkg::KIND_PIXEL: begin
        dec.op = fsbg_pkg::OP_PIXEL;
        keep   = 1'b1;
      end
      fsbg_pkg::KIND_CLEAR: begin
        dec.op = fsbg_pkg::OP_CLEAR;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(cmd_pop);
    end
    if (push) q_r[wr_ptr_r] <= dec;
  end

endmodule

### rtl/fsbg_back.sv
module fsbg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  fsbg_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic [11:0]    picture_width,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_luma_out
);

  localparam int AW = fsbg_pkg::ADDR_W;
  localparam int CW = fsbg_pkg::CNT_W;
  localparam int SW = fsbg_pkg::SIZE_W;

  fsbg_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [SW-1:0] wmax_r, wmax_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          pend_r, pend_nxt;
  logic          outv_r, outv_nxt;
  logic [7:0]    outl_r, outl_nxt;
  logic [7:0]    luma_r, luma_nxt;
  logic [11:0]   dist_r, dist_nxt;
  logic [fsbg_pkg::HQ_W-1:0]    hq_r, hq_nxt;
  logic [fsbg_pkg::FKIND_W-1:0] fk_r, fk_nxt;
  logic [fsbg_pkg::PROD_W-1:0]  prod_r, prod_nxt;

  logic          we;
  logic [AW-1:0] raddr;
  logic [fsbg_pkg::ENT_W-1:0] rdata;
  logic [CW-1:0] w, fill_new, cnt;
  logic          out_free, div_start, div_done, stored;
  logic [fsbg_pkg::PROD_W-1:0] quo;

  fsbg_ram #(.WIDTH(fsbg_pkg::ENT_W), .DEPTH(fsbg_pkg::HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata ({cmd.fkind, cmd.size}),
    .raddr (raddr),
    .rdata (rdata)
  );

  fsbg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (wmax_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    wmax_nxt  = wmax_r;
    acc_nxt   = acc_r;
    scan_nxt  = scan_r;
    rem_nxt   = rem_r;
    pend_nxt  = 1'b0;
    luma_nxt  = luma_r;
    dist_nxt  = dist_r;
    hq_nxt    = hq_r;
    fk_nxt    = fk_r;
    prod_nxt  = prod_r;
    out_free  = !outv_r || !out_stall;
    outv_nxt  = outv_r && out_stall;
    outl_nxt  = outl_r;
    cmd_pop   = 1'b0;
    we        = 1'b0;
    div_start = 1'b0;
    w         = fsbg_pkg::win_width(picture_width);
    fill_new  = (32'(fill_r) >= fsbg_pkg::HIST_DEPTH) ? fill_r : fill_r + 1'b1;
    cnt       = (w < fill_new) ? w : fill_new;
    // history entry for a pixel: newest sits just below the write pointer
    raddr     = AW'(32'(wp_r) + 32'(cmd.col) - 32'(w));
    stored    = (32'(cmd.col) + 32'(fill_r)) >= 32'(w);
    unique case (state_r)
      fsbg_pkg::S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            fsbg_pkg::OP_FRAME: begin
              we        = 1'b1;
              cmd_pop   = 1'b1;
              wp_nxt    = wp_r + 1'b1;
              fill_nxt  = fill_new;
              acc_nxt   = '0;
              rem_nxt   = cnt;
              scan_nxt  = AW'(32'(wp_r) + 32'd1 - 32'(cnt));
              state_nxt = fsbg_pkg::S_MAX;
            end
            fsbg_pkg::OP_CLEAR: begin
              cmd_pop  = 1'b1;
              fill_nxt = '0;
              wmax_nxt = '0;
            end
            default: begin
              if (cmd.hit && wmax_r != '0 && stored) begin
                cmd_pop   = 1'b1;
                luma_nxt  = cmd.luma;
                dist_nxt  = cmd.rows_up;
                hq_nxt    = cmd.hq;
                state_nxt = fsbg_pkg::S_PX_MUL;
              end else if (out_free) begin
                cmd_pop  = 1'b1;
                outv_nxt = 1'b1;
                outl_nxt = cmd.luma;
              end
            end
          endcase
        end
      end
      fsbg_pkg::S_MAX: begin
        // one read issued per cycle, compared in the cycle after
        raddr = scan_r;
        if (pend_r && rdata[SW-1:0] > acc_r) acc_nxt = rdata[SW-1:0];
        if (rem_r != '0) begin
          scan_nxt = scan_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          wmax_nxt  = acc_r;
          state_nxt = fsbg_pkg::S_IDLE;
        end
      end
      fsbg_pkg::S_PX_MUL: begin
        prod_nxt  = fsbg_pkg::PROD_W'(hq_r) * fsbg_pkg::PROD_W'(rdata[SW-1:0]);
        fk_nxt    = rdata[fsbg_pkg::ENT_W-1:SW];
        state_nxt = fsbg_pkg::S_DIV_GO;
      end
      fsbg_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = fsbg_pkg::S_DIV_WAIT;
      end
      fsbg_pkg::S_DIV_WAIT: begin
        if (div_done) state_nxt = fsbg_pkg::S_PX_OUT;
      end
      fsbg_pkg::S_PX_OUT: begin
        // row lies under the bar when its distance from the bottom is below it
        if (out_free) begin
          outv_nxt  = 1'b1;
          outl_nxt  = (fsbg_pkg::PROD_W'(dist_r) < quo) ? fsbg_pkg::type_luma(fk_r)
                                                          : luma_r;
          state_nxt = fsbg_pkg::S_IDLE;
        end
      end
      default: state_nxt = fsbg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsbg_pkg::S_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      wmax_r  <= '0;
      rem_r   <= '0;
      pend_r  <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      wmax_r  <= wmax_nxt;
      rem_r   <= rem_nxt;
      pend_r  <= pend_nxt;
      outv_r  <= outv_nxt;
    end
    acc_r  <= acc_nxt;
    scan_r <= scan_nxt;
    luma_r <= luma_nxt;
    dist_r <= dist_nxt;
    hq_r   <= hq_nxt;
    fk_r   <= fk_nxt;
    prod_r <= prod_nxt;
    outl_r <= outl_nxt;
  end

  assign out_valid    = outv_r;
  assign out_luma_out = outl_r;

endmodule

### rtl/fsbg_checker.sv
module fsbg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_luma_out,
  input logic       cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_luma_out))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind frame_size_bar_graph_overlay_top fsbg_checker u_fsbg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_luma_out (out_luma_out),
  .cfg_ready    (cfg_ready)
);
